// File: rtl/smls_pkg.sv
// Shared types and constants for the segmented load/store unit.
// No dependencies; imported by smls_map and segmented_memory_load_store.
`default_nettype none

package smls_pkg;

    // Width of an exact (unwrapped) store index or region bound.
    localparam int unsigned FULL_W = 33;

    // Operation codes carried on func.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_STORE = 1'b1;

    // access_size codes.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    // status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SEGV  = 2'd1;
    localparam logic [1:0] STATUS_ALIGN = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TEXT_START   = 3'd0;
    localparam logic [2:0] REG_DATA_START   = 3'd1;
    localparam logic [2:0] REG_STACK_TOP    = 3'd2;
    localparam logic [2:0] REG_TEXT_OFFSET  = 3'd3;
    localparam logic [2:0] REG_DATA_OFFSET  = 3'd4;
    localparam logic [2:0] REG_STACK_OFFSET = 3'd5;

    // Region setup plus the two derived upper bounds, kept in step on every write.
    typedef struct packed {
        logic [31:0]       text_start;
        logic [31:0]       data_start;
        logic [31:0]       stack_top;
        logic [15:0]       text_offset;
        logic [15:0]       data_offset;
        logic [15:0]       stack_offset;
        logic [FULL_W-1:0] text_end;   // text start + text length
        logic [FULL_W-1:0] data_end;   // data start + data length
    } smls_cfg_t;

    localparam smls_cfg_t CFG_RESET = '{
        text_start:   32'h0000_0000,
        data_start:   32'h1000_0000,
        stack_top:    32'h8000_0000,
        text_offset:  16'd0,
        data_offset:  16'd16384,
        stack_offset: 16'd32768,
        text_end:     33'h0_0000_4000,
        data_end:     33'h0_1000_4000
    };

    // Address translation result.
    typedef struct packed {
        logic              hit;
        logic [FULL_W-1:0] idx;
    } smls_map_t;

endpackage

`default_nettype wire

// File: rtl/smls_ram.sv
// Generic single-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module smls_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: rtl/smls_map.sv
// Region map: emulated address to exact byte-store index (stack, data, text).
// Depends on smls_pkg.
`default_nettype none

module smls_map
    import smls_pkg::*;
(
    input  wire smls_cfg_t   cfg,
    input  wire logic [31:0] address,
    input  wire logic        is_store,
    output      smls_map_t   res
);

    logic [FULL_W-1:0] a_full;
    logic              in_stack;
    logic              in_data;
    logic              in_text;
    logic [FULL_W-1:0] stack_idx;
    logic [31:0]       data_rel;
    logic [31:0]       text_rel;
    logic [FULL_W-1:0] data_idx;
    logic [FULL_W-1:0] text_idx;

    assign a_full   = {1'b0, address};
    assign in_stack = (a_full >= cfg.data_end) && (address < cfg.stack_top);
    assign in_data  = (address >= cfg.data_start) && (a_full < cfg.data_end);
    assign in_text  = !is_store && (address >= cfg.text_start) && (a_full < cfg.text_end);

    // stack grows down: index counts from stack_top
    assign stack_idx = {1'b0, cfg.stack_top} - a_full + FULL_W'(cfg.stack_offset);

    // relative offsets are below the 16-bit region length when in range
    assign data_rel = address - cfg.data_start;
    assign text_rel = address - cfg.text_start;
    assign data_idx = FULL_W'(cfg.data_offset) + FULL_W'(data_rel[15:0]);
    assign text_idx = FULL_W'(cfg.text_offset) + FULL_W'(text_rel[15:0]);

    always_comb
    begin
        res.hit = in_stack || in_data || in_text;
        if (in_stack)
        begin
            res.idx = stack_idx;
        end
        else if (in_data)
        begin
            res.idx = data_idx;
        end
        else
        begin
            res.idx = text_idx;
        end
    end

endmodule

`default_nettype wire

// File: rtl/segmented_memory_load_store.sv
// Segmented load/store unit: region map, bounds/alignment checks, four byte-lane RAMs.
// Depends on smls_pkg, smls_map and smls_ram.
//
//  channel   | handshake        | payload
//  ----------+------------------+-----------------------------------------------------
//  command   | start, busy      | func, address, access_size, write_data, align_check
//  result    | done (strobe)    | read_data, status
//  config    | cfg_write        | cfg_index, cfg_data
//
// A command beat is taken on every edge where start is high; busy is never raised.
// Each beat gives one result beat, in order, one per cycle.
// Pipeline: input register -> region map register -> lane RAM read/write -> result
// register. The four byte lanes let any unaligned halfword or word reach its bytes
// in one RAM access, so throughput is one beat per cycle.
// The result side cannot stall; done is held for one cycle only.
// Reset clears the pipeline valids and loads the region registers with their
// defaults; the byte store itself is not cleared.
`default_nettype none

module segmented_memory_load_store
    import smls_pkg::*;
#(
    parameter int unsigned STORE_BYTES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command
    input  wire logic        start,
    output      logic        busy,
    input  wire logic        func,
    input  wire logic [31:0] address,
    input  wire logic [1:0]  access_size,
    input  wire logic [31:0] write_data,
    input  wire logic        align_check,
    // configuration
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // result
    output      logic        done,
    output      logic [31:0] read_data,
    output      logic [1:0]  status
);

    localparam int unsigned IDX_W     = $clog2(STORE_BYTES);
    localparam int unsigned ROW_DEPTH = (STORE_BYTES + 3) / 4;
    localparam int unsigned ROW_W     = $clog2(ROW_DEPTH);
    localparam logic [FULL_W:0] STORE_LIMIT = (FULL_W + 1)'(STORE_BYTES);

    // command side never stalls
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Region registers; derived bounds follow the written value directly
    // ------------------------------------------------------------------
    smls_cfg_t cfg_reg;
    smls_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_TEXT_START:   cfg_next.text_start   = cfg_data;
                REG_DATA_START:   cfg_next.data_start   = cfg_data;
                REG_STACK_TOP:    cfg_next.stack_top    = cfg_data;
                REG_TEXT_OFFSET:  cfg_next.text_offset  = cfg_data[15:0];
                REG_DATA_OFFSET:  cfg_next.data_offset  = cfg_data[15:0];
                REG_STACK_OFFSET: cfg_next.stack_offset = cfg_data[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
        // lengths clamp to zero when the offsets are out of order
        cfg_next.text_end = {1'b0, cfg_next.text_start} +
            ((cfg_next.data_offset >= cfg_next.text_offset)
                ? FULL_W'(cfg_next.data_offset - cfg_next.text_offset) : '0);
        cfg_next.data_end = {1'b0, cfg_next.data_start} +
            ((cfg_next.stack_offset >= cfg_next.data_offset)
                ? FULL_W'(cfg_next.stack_offset - cfg_next.data_offset) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic        s1_store_reg;
    logic [31:0] s1_addr_reg;
    logic [1:0]  s1_size_reg;
    logic [31:0] s1_wdata_reg;
    logic        s1_chk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_store_reg <= (func == FUNC_STORE);
            s1_addr_reg  <= address;
            s1_size_reg  <= access_size;
            s1_wdata_reg <= write_data;
            s1_chk_reg   <= align_check;
        end
    end

    smls_map_t s1_map;

    smls_map u_map (
        .cfg      (cfg_reg),
        .address  (s1_addr_reg),
        .is_store (s1_store_reg),
        .res      (s1_map)
    );

    // alignment fault, applied only if the segment checks pass
    logic s1_align_bad;

    always_comb
    begin
        case (s1_size_reg)
            SIZE_BYTE: s1_align_bad = 1'b0;
            SIZE_HALF: s1_align_bad = s1_addr_reg[0];
            SIZE_WORD: s1_align_bad = |s1_addr_reg[1:0];
            default:   s1_align_bad = 1'b1;
        endcase
        s1_align_bad = s1_align_bad && s1_chk_reg;
    end

    // ------------------------------------------------------------------
    // Stage 2: bounds check and lane RAM access
    // ------------------------------------------------------------------
    logic        s2_valid_reg;
    logic        s2_store_reg;
    logic [1:0]  s2_size_reg;
    logic [31:0] s2_wdata_reg;
    logic        s2_align_bad_reg;
    smls_map_t   s2_map_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_store_reg     <= s1_store_reg;
        s2_size_reg      <= s1_size_reg;
        s2_wdata_reg     <= s1_wdata_reg;
        s2_align_bad_reg <= s1_align_bad;
        s2_map_reg       <= s1_map;
    end

    logic [2:0]       s2_nbytes;
    logic [2:0]       s2_span;
    logic [FULL_W:0]  s2_end;
    logic             s2_seg_bad;
    logic [1:0]       s2_status;
    logic [1:0]       s2_off;
    logic [ROW_W-1:0] s2_base_row;
    logic [3:0]       s2_we;
    logic [ROW_W-1:0] s2_row [4];
    logic [7:0]       s2_wbyte [4];

    always_comb
    begin
        case (s2_size_reg)
            SIZE_BYTE: s2_nbytes = 3'd1;
            SIZE_HALF: s2_nbytes = 3'd2;
            SIZE_WORD: s2_nbytes = 3'd4;
            default:   s2_nbytes = 3'd0;
        endcase
    end

    // an access touching no bytes still needs its index inside the store
    assign s2_span    = (s2_nbytes == 3'd0) ? 3'd1 : s2_nbytes;
    assign s2_end     = {1'b0, s2_map_reg.idx} + (FULL_W + 1)'(s2_span);
    assign s2_seg_bad = !s2_map_reg.hit || (s2_end > STORE_LIMIT);

    always_comb
    begin
        if (s2_seg_bad)
        begin
            s2_status = STATUS_SEGV;
        end
        else if (s2_align_bad_reg)
        begin
            s2_status = STATUS_ALIGN;
        end
        else
        begin
            s2_status = STATUS_OK;
        end
    end

    // byte k of the access sits in lane (idx + k) mod 4
    assign s2_off      = s2_map_reg.idx[1:0];
    assign s2_base_row = s2_map_reg.idx[IDX_W-1:2];

    always_comb
    begin
        logic [1:0] k;
        for (int l = 0; l < 4; l++)
        begin
            k            = 2'(l) - s2_off;
            s2_row[l]    = s2_base_row + ROW_W'(2'(l) < s2_off);
            s2_wbyte[l]  = s2_wdata_reg[{k, 3'b000} +: 8];
            s2_we[l]     = s2_valid_reg && s2_store_reg && (s2_status == STATUS_OK) &&
                           ({1'b0, k} < s2_nbytes);
        end
    end

    logic [7:0] lane_q [4];

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        smls_ram #(
            .WIDTH (8),
            .DEPTH (ROW_DEPTH)
        ) u_lane_ram (
            .clk   (clk),
            .we    (s2_we[g]),
            .addr  (s2_row[g]),
            .wdata (s2_wbyte[g]),
            .rdata (lane_q[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 3: byte gather; result register
    // ------------------------------------------------------------------
    logic       s3_valid_reg;
    logic [1:0] s3_status_reg;
    logic       s3_load_reg;
    logic [1:0] s3_off_reg;
    logic [2:0] s3_nbytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_status_reg <= s2_status;
        s3_load_reg   <= !s2_store_reg && (s2_status == STATUS_OK);
        s3_off_reg    <= s2_off;
        s3_nbytes_reg <= s2_nbytes;
    end

    logic [31:0] read_data_next;

    always_comb
    begin
        logic [1:0] lane;
        read_data_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            lane = s3_off_reg + 2'(k);
            if (s3_load_reg && (3'(k) < s3_nbytes_reg))
            begin
                read_data_next[8*k +: 8] = lane_q[lane];
            end
        end
    end

    logic        done_reg;
    logic [31:0] read_data_reg;
    logic [1:0]  status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        status_reg    <= s3_status_reg;
    end

    assign done      = done_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result beat missing four cycles after command beat");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result beat without a matching command beat");

    a_fault_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (read_data == 32'd0))
        else $error("faulting access returned nonzero data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STATUS_OK || status == STATUS_SEGV || status == STATUS_ALIGN))
        else $error("undefined status code on result beat");

    a_write_only_clean_store: assert property (@(posedge clk) disable iff (!rst_n)
        (|s2_we) |-> (s2_valid_reg && s2_store_reg && !s2_seg_bad && !s2_align_bad_reg))
        else $error("lane write on a load or a faulting store");

endmodule

`default_nettype wire
